>>> design/infix_to_postfix_converter_assert.svh
// assertion macros shared by the converter modules
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication on the block clock
`define ITPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("itpc assertion failed");
// next-cycle implication on the block clock
`define ITPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("itpc assertion failed");
`else
`define ITPC_ASSERT_SAME(label, ante, cons)
`define ITPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/itpc_pkg.sv
package itpc_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        KIND_OPERAND,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_OPERATOR
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_TEST,
        ST_TAIL,
        ST_FREAD,
        ST_FTEST,
        ST_END
    } state_t;

    // sequencer to stack
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       rd_en;
        logic [7:0] wr_data;
    } stk_ctrl_t;

    // stack to sequencer
    typedef struct packed {
        logic       empty;
        logic [7:0] top;
    } stk_stat_t;

    // operator precedence
    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
        if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
        if (c == CH_CARET) p = 2'd3;
        return p;
    endfunction

    // character class
    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A)) begin
            k = KIND_OPERAND;
        end else if (c == CH_LPAREN) begin
            k = KIND_LPAREN;
        end else if (c == CH_RPAREN) begin
            k = KIND_RPAREN;
        end else begin
            k = KIND_OPERATOR;
        end
        return k;
    endfunction

endpackage

>>> design/itpc_stack.sv
`include "infix_to_postfix_converter_assert.svh"

module itpc_stack (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  itpc_pkg::stk_ctrl_t   ctrl,
    output itpc_pkg::stk_stat_t   stat
);

    logic [7:0]                 mem [itpc_pkg::STACK_DEPTH];
    logic [itpc_pkg::CNT_W-1:0] count_reg;
    logic [itpc_pkg::CNT_W-1:0] count_next;
    logic [itpc_pkg::CNT_W-1:0] count_m1;
    logic [7:0]                 rd_data_reg;
    logic                       full;

    assign full     = (count_reg == itpc_pkg::CNT_W'(itpc_pkg::STACK_DEPTH));
    assign count_m1 = count_reg - itpc_pkg::CNT_W'(1);

    // fill count, push onto a full stack is dropped
    always_comb begin
        count_next = count_reg;
        if (ctrl.push && !full) begin
            count_next = count_reg + itpc_pkg::CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // stack memory, write at count, registered read of the top
    always_ff @(posedge aclk) begin
        if (ctrl.push && !full) begin
            mem[count_reg[itpc_pkg::ADDR_W-1:0]] <= ctrl.wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[count_m1[itpc_pkg::ADDR_W-1:0]];
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.top   = rd_data_reg;

    `ITPC_ASSERT_SAME(a_count_range, 1'b1, count_reg <= itpc_pkg::CNT_W'(itpc_pkg::STACK_DEPTH))
    `ITPC_ASSERT_SAME(a_pop_nonempty, ctrl.pop, count_reg != '0)
    `ITPC_ASSERT_NEXT(a_full_drop, ctrl.push && full, $stable(count_reg))

endmodule

>>> design/infix_to_postfix_converter.sv
// channel   ports                                       role
// s_        s_valid s_ready s_in_char s_last_char       infix characters in
// m_        m_valid m_ready m_out_char m_last_in_run    postfix characters out
//           m_expression_done
//
// an operand is emitted and a '(' pushed from the start state; every pop of the operator stack
// is a registered stack read, then a compare and emit
// a last character flushes each stack entry the same way, then emits the terminator
// reset clears the sequencer and the stack count; stack memory is not cleared
// results pass hold stage and output reg; emits stall if both full, m_ready low
`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_in_run,
    output logic       m_expression_done
);

    itpc_pkg::state_t    state_reg;
    itpc_pkg::state_t    state_next;
    itpc_pkg::kind_t     kind_reg;
    logic [7:0]          char_reg;
    logic                last_reg;

    logic                pend_valid_reg;
    logic [7:0]          pend_char_reg;
    logic                pend_done_reg;

    logic                m_valid_reg;
    logic [7:0]          m_char_reg;
    logic                m_last_reg;
    logic                m_done_reg;

    itpc_pkg::stk_ctrl_t ctrl;
    itpc_pkg::stk_stat_t stat;

    logic                out_free;
    logic                can_emit;
    logic                emit;
    logic [7:0]          emit_char;
    logic                emit_done;
    logic                fin;
    logic                go;
    logic [1:0]          top_prec;
    logic [1:0]          cur_prec;

    itpc_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign can_emit = !pend_valid_reg || out_free;

    // pop test, '^' binds to the right
    assign top_prec = itpc_pkg::prec_of(stat.top);
    assign cur_prec = itpc_pkg::prec_of(char_reg);
    assign go = (char_reg == itpc_pkg::CH_CARET) ? (top_prec > cur_prec)
                                                 : (top_prec >= cur_prec);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        emit         = 1'b0;
        emit_char    = stat.top;
        emit_done    = 1'b0;
        fin          = 1'b0;
        ctrl.push    = 1'b0;
        ctrl.pop     = 1'b0;
        ctrl.rd_en   = 1'b0;
        ctrl.wr_data = char_reg;
        unique case (state_reg)
            itpc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = itpc_pkg::ST_START;
                end
            end
            itpc_pkg::ST_START: begin
                unique case (kind_reg)
                    itpc_pkg::KIND_OPERAND: begin
                        if (can_emit) begin
                            emit       = 1'b1;
                            emit_char  = char_reg;
                            state_next = itpc_pkg::ST_TAIL;
                        end
                    end
                    itpc_pkg::KIND_LPAREN: begin
                        ctrl.push  = 1'b1;
                        state_next = itpc_pkg::ST_TAIL;
                    end
                    default: begin
                        state_next = itpc_pkg::ST_READ;
                    end
                endcase
            end
            itpc_pkg::ST_READ: begin
                if (stat.empty) begin
                    ctrl.push  = (kind_reg == itpc_pkg::KIND_OPERATOR);
                    state_next = itpc_pkg::ST_TAIL;
                end else begin
                    ctrl.rd_en = 1'b1;
                    state_next = itpc_pkg::ST_TEST;
                end
            end
            itpc_pkg::ST_TEST: begin
                if (kind_reg == itpc_pkg::KIND_RPAREN) begin
                    if (stat.top == itpc_pkg::CH_LPAREN) begin
                        ctrl.pop   = 1'b1;
                        state_next = itpc_pkg::ST_TAIL;
                    end else if (can_emit) begin
                        emit       = 1'b1;
                        ctrl.pop   = 1'b1;
                        state_next = itpc_pkg::ST_READ;
                    end
                end else if (go) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        ctrl.pop   = 1'b1;
                        state_next = itpc_pkg::ST_READ;
                    end
                end else begin
                    ctrl.push  = 1'b1;
                    state_next = itpc_pkg::ST_TAIL;
                end
            end
            itpc_pkg::ST_TAIL: begin
                state_next = last_reg ? itpc_pkg::ST_FREAD : itpc_pkg::ST_END;
            end
            itpc_pkg::ST_FREAD: begin
                if (stat.empty) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        emit_char  = itpc_pkg::CH_NUL;
                        emit_done  = 1'b1;
                        state_next = itpc_pkg::ST_END;
                    end
                end else begin
                    ctrl.rd_en = 1'b1;
                    state_next = itpc_pkg::ST_FTEST;
                end
            end
            itpc_pkg::ST_FTEST: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    ctrl.pop   = 1'b1;
                    state_next = itpc_pkg::ST_FREAD;
                end
            end
            itpc_pkg::ST_END: begin
                if (!pend_valid_reg) begin
                    state_next = itpc_pkg::ST_IDLE;
                end else if (out_free) begin
                    fin        = 1'b1;
                    state_next = itpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itpc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= itpc_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                pend_valid_reg <= 1'b1;
            end else if (fin) begin
                pend_valid_reg <= 1'b0;
            end
            if ((emit && pend_valid_reg) || fin) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input capture, hold stage and output payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_in_char;
            last_reg <= s_last_char;
            kind_reg <= itpc_pkg::classify(s_in_char);
        end
        if ((emit && pend_valid_reg) || fin) begin
            m_char_reg <= pend_char_reg;
            m_done_reg <= pend_done_reg;
            m_last_reg <= fin;
        end
        if (emit) begin
            pend_char_reg <= emit_char;
            pend_done_reg <= emit_done;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_char        = m_char_reg;
    assign m_last_in_run     = m_last_reg;
    assign m_expression_done = m_done_reg;

    `ITPC_ASSERT_SAME(a_done_is_term, m_valid_reg && m_done_reg, (m_char_reg == itpc_pkg::CH_NUL) && m_last_reg)
    `ITPC_ASSERT_SAME(a_idle_no_pend, state_reg == itpc_pkg::ST_IDLE, !pend_valid_reg)
    `ITPC_ASSERT_NEXT(a_fin_marks_last, fin, m_valid_reg && m_last_reg && !pend_valid_reg)

endmodule
